### rtl/core/edge_pair_value_map_unit_macros.svh
// Assertion shorthands for the edge pair value map.
// Each one samples on clk_i and is off while rst_ni is low.
`ifndef EDGE_PAIR_VALUE_MAP_UNIT_MACROS_SVH
`define EDGE_PAIR_VALUE_MAP_UNIT_MACROS_SVH

// Check that a consequence holds in the same cycle as its cause.
`define EPVM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequence holds in the cycle after its cause.
`define EPVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/epvm_pkg.sv
package epvm_pkg;

  // Table geometry
  localparam int unsigned VERTEX_COUNT = 1024;
  localparam int unsigned POOL_ENTRIES = 4096;

  // Field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned VERT_W = 10;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned STAT_W = 3;

  // Memory address and link widths; a link is an entry number plus one, zero for none
  localparam int unsigned HEAD_AW = $clog2(VERTEX_COUNT);
  localparam int unsigned POOL_AW = $clog2(POOL_ENTRIES);
  localparam int unsigned LINK_W  = $clog2(POOL_ENTRIES + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND   = 3'd0,
    ST_MISSING = 3'd1,
    ST_INSERTED = 3'd2,
    ST_PRESENT = 3'd3,
    ST_INVALID = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef struct packed {
    mode_e             mode;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic [VAL_W-1:0]  new_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] result_value;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    logic [VERT_W-1:0] vertex;
    logic [LINK_W-1:0] next;
    logic [VAL_W-1:0]  value;
  } entry_t;

endpackage

### rtl/core/edge_pair_value_map_unit.sv
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+-----------------------
// in      | input     | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
// out     | output    | out_valid_o / out_stall_i| out_item_o (out_item_t)
//
// Lookup and insert read the head table row of the lower vertex, then walk
// its chain with one read of the entry memory per entry visited.
// Clear zeroes one head table row per cycle.
// After reset the same clearing pass runs with the input stalled; it
// returns no item.
// One item is worked at a time; a new item is taken while a result waits
// in the output register, and a stalled output holds the walk at its end.
`include "edge_pair_value_map_unit_macros.svh"

module edge_pair_value_map_unit import epvm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_ENT   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [LINK_W-1:0]  POOL_FULL = LINK_W'(POOL_ENTRIES);
  localparam logic [HEAD_AW-1:0] HEAD_LAST = HEAD_AW'(VERTEX_COUNT - 1);

  // Control registers
  logic [2:0]         state_q, state_d;
  logic [HEAD_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic               clr_reply_q, clr_reply_d;
  logic [LINK_W-1:0]  pool_used_q, pool_used_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers
  in_item_t          item_q, item_d;
  logic [VERT_W-1:0] lo_q, lo_d;
  logic [VERT_W-1:0] hi_q, hi_d;
  logic [LINK_W-1:0] head_link_q, head_link_d;
  logic              hit_q, hit_d;
  logic [VAL_W-1:0]  hit_val_q, hit_val_d;
  out_item_t         res_q, res_d;
  out_item_t         out_item_q;
  logic              out_load;

  // Memories and their ports
  logic [LINK_W-1:0]  head_mem [VERTEX_COUNT];
  entry_t             entry_mem [POOL_ENTRIES];
  logic [LINK_W-1:0]  head_rd_q;
  entry_t             entry_rd_q;
  logic               head_re, head_we;
  logic [HEAD_AW-1:0] head_raddr, head_waddr;
  logic [LINK_W-1:0]  head_wdata;
  logic               entry_re, entry_we;
  logic [POOL_AW-1:0] entry_raddr, entry_waddr;
  entry_t             entry_wdata;

  // Decode of the incoming pair and of links read back
  logic              in_bad;
  logic [LINK_W-1:0] head_m1, next_m1;

  assign in_bad = (in_item_i.vertex_a == in_item_i.vertex_b)
               || (32'(in_item_i.vertex_a) >= VERTEX_COUNT)
               || (32'(in_item_i.vertex_b) >= VERTEX_COUNT);
  assign head_m1 = head_rd_q - LINK_W'(1);
  assign next_m1 = entry_rd_q.next - LINK_W'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Sequence one item: head read, chain walk, update, result; or the clearing pass
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_reply_d = clr_reply_q;
    pool_used_d = pool_used_q;
    item_d      = item_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    head_link_d = head_link_q;
    hit_d       = hit_q;
    hit_val_d   = hit_val_q;
    res_d       = res_q;
    out_load    = 1'b0;
    head_re     = 1'b0;
    head_raddr  = lo_q[HEAD_AW-1:0];
    head_we     = 1'b0;
    head_waddr  = clr_cnt_q;
    head_wdata  = '0;
    entry_re    = 1'b0;
    entry_raddr = head_m1[POOL_AW-1:0];
    entry_we    = 1'b0;
    entry_waddr = pool_used_q[POOL_AW-1:0];
    entry_wdata = '{vertex: hi_q, next: head_link_q, value: item_q.new_value};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          if (in_item_i.vertex_a < in_item_i.vertex_b) begin
            lo_d = in_item_i.vertex_a;
            hi_d = in_item_i.vertex_b;
          end else begin
            lo_d = in_item_i.vertex_b;
            hi_d = in_item_i.vertex_a;
          end
          case (in_item_i.mode)
            MODE_CLEAR: begin
              clr_cnt_d   = '0;
              clr_reply_d = 1'b1;
              state_d     = S_CLEAR;
            end
            MODE_LOOKUP, MODE_INSERT: begin
              if (in_bad) begin
                res_d   = '{found: 1'b0, result_value: '0, status: ST_INVALID};
                state_d = S_DONE;
              end else begin
                head_re    = 1'b1;
                head_raddr = lo_d[HEAD_AW-1:0];
                state_d    = S_HEAD;
              end
            end
            default: begin
              res_d   = '{found: 1'b0, result_value: '0, status: ST_MISSING};
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_HEAD: begin
        head_link_d = head_rd_q;
        if (head_rd_q == '0) begin
          hit_d   = 1'b0;
          state_d = S_FIN;
        end else begin
          entry_re    = 1'b1;
          entry_raddr = head_m1[POOL_AW-1:0];
          state_d     = S_ENT;
        end
      end
      S_ENT: begin
        // Compare, then follow the next link
        if (entry_rd_q.vertex == hi_q) begin
          hit_d     = 1'b1;
          hit_val_d = entry_rd_q.value;
          state_d   = S_FIN;
        end else if (entry_rd_q.next == '0) begin
          hit_d   = 1'b0;
          state_d = S_FIN;
        end else begin
          entry_re    = 1'b1;
          entry_raddr = next_m1[POOL_AW-1:0];
        end
      end
      S_FIN: begin
        state_d = S_DONE;
        case (item_q.mode)
          MODE_LOOKUP: begin
            if (hit_q) begin
              res_d = '{found: 1'b1, result_value: hit_val_q, status: ST_FOUND};
            end else begin
              res_d = '{found: 1'b0, result_value: '0, status: ST_MISSING};
            end
          end
          MODE_INSERT: begin
            if (hit_q) begin
              res_d = '{found: 1'b1, result_value: hit_val_q, status: ST_PRESENT};
            end else if (pool_used_q == POOL_FULL) begin
              res_d = '{found: 1'b0, result_value: '0, status: ST_FULL};
            end else begin
              // Push a new entry at the chain head
              entry_we    = 1'b1;
              head_we     = 1'b1;
              head_waddr  = lo_q[HEAD_AW-1:0];
              head_wdata  = pool_used_q + LINK_W'(1);
              pool_used_d = pool_used_q + LINK_W'(1);
              res_d = '{found: 1'b1, result_value: item_q.new_value, status: ST_INSERTED};
            end
          end
          default: begin
            res_d = '{found: 1'b0, result_value: '0, status: ST_MISSING};
          end
        endcase
      end
      S_CLEAR: begin
        // Zero one head row a cycle
        head_we    = 1'b1;
        head_waddr = clr_cnt_q;
        if (clr_cnt_q == HEAD_LAST) begin
          pool_used_d = '0;
          if (clr_reply_q) begin
            res_d   = '{found: 1'b0, result_value: '0, status: ST_MISSING};
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          clr_cnt_d = clr_cnt_q + HEAD_AW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output item until it is taken
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Advance control state; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      pool_used_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_reply_q <= clr_reply_d;
      pool_used_q <= pool_used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture item payload and walk results
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    head_link_q <= head_link_d;
    hit_q       <= hit_d;
    hit_val_q   <= hit_val_d;
    res_q       <= res_d;
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  // Head table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd_q <= head_mem[head_raddr];
    end
  end

  // Entry pool: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    if (entry_re) begin
      entry_rd_q <= entry_mem[entry_raddr];
    end
  end

  // Checks
  `EPVM_ASSERT_SAME(a_pool_bound, 1'b1, pool_used_q <= POOL_FULL, "pool count beyond pool size")
  `EPVM_ASSERT_NEXT(a_insert_grows,
    state_q == S_FIN && entry_we, pool_used_q == $past(pool_used_q) + LINK_W'(1),
    "insert did not advance pool count")
  `EPVM_ASSERT_NEXT(a_clear_frees,
    state_q == S_CLEAR && clr_cnt_q == HEAD_LAST, pool_used_q == '0,
    "clear pass did not free the pool")
  `EPVM_ASSERT_SAME(a_found_status, out_valid_o,
    out_item_o.found == (out_item_o.status == ST_FOUND || out_item_o.status == ST_PRESENT
                         || out_item_o.status == ST_INSERTED),
    "found flag disagrees with status")

endmodule
